FILE: rtl/assert_macros.svh
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define BTSP_ASSERT_IMPL(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BTSP_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/btsp_pkg.sv
package btsp_pkg;

  localparam int MaxColumns = 1024;
  localparam int MaxRows    = 1024;

  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 11;

  // Dimension arithmetic width: holds the clamped width, height and drain index.
  localparam int DimW = CfgDataW;
  localparam int ColW = $clog2(MaxColumns);
  localparam int RowW = $clog2(MaxRows + 1);

  localparam logic [DimW-1:0] WidthReset  = DimW'(640);
  localparam logic [DimW-1:0] HeightReset = DimW'(480);
  localparam logic [DimW-1:0] DimMin      = DimW'(3);

  typedef enum logic [CfgIdxW-1:0] {
    CfgImageWidth  = 1'b0,
    CfgImageHeight = 1'b1
  } cfg_idx_e;

  localparam logic ModePixel = 1'b0;
  localparam logic ModeDrain = 1'b1;

  // Control carried from the read stage to the write-back stage.
  typedef struct packed {
    logic            pix;       // pixel request (else drain)
    logic            emit;      // produces a result
    logic            col0;      // column zero: result comes from wrap register
    logic            lastcol;   // last column: capture wrap value
    logic            interior;  // thinning rule applies
    logic            pin;       // incoming pixel
    logic            last;      // final drain request of the frame
    logic            dj0;       // first drain request
    logic [ColW-1:0] wa;        // line store write address
  } s1_ctl_t;

endpackage

FILE: rtl/btsp_ram.sv
module btsp_ram #(
  parameter int Width = 1,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    // Hold read data when no read is issued.
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/binary_thinning_subpass_3x3_unit.sv
// Channel | Handshake               | Payload
// --------+-------------------------+-------------------------------
// in      | in_valid_i / in_stall_o | mode_i, pixel_in_i
// out     | out_valid_o/out_stall_i | pixel_out_o, frame_last_o
// cfg     | cfg_we_i                | cfg_idx_i, cfg_wdata_i
//
// One request per cycle sustained while the output is not stalled; a result goes
// through the line store read, then write-back into the output register.
// The rate is set by the line stores: each pixel request does one read and one
// write per store, on separate ports.
// Reset clears counters, window and output valid; line stores keep their contents.
// in_stall_o rises only when a result waits in the read stage and the output
// register is full and stalled.
`include "assert_macros.svh"

module binary_thinning_subpass_3x3_unit import btsp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                mode_i,
  input  logic                pixel_in_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                pixel_out_o,
  output logic                frame_last_o
);

  // Configuration registers.
  logic [DimW-1:0] width_q, height_q;
  logic [DimW-1:0] w_eff, h_eff;
  logic [ColW-1:0] w_last;
  logic [RowW-1:0] h_row;

  // Frame position.
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic [DimW-1:0] drn_q, drn_d;
  logic [DimW-1:0] drn_m1;

  // Read stage.
  logic    s1_valid_q, s1_valid_d;
  s1_ctl_t s1_q, s1_d;
  logic    s1_go;

  // Window and wrap value.
  logic [8:0] win_q, win_d, win_nxt;
  logic       wrap_q, wrap_d;

  // Output register.
  logic out_valid_q, out_valid_d;
  logic pix_out_q, pix_out_d;
  logic last_out_q, last_out_d;
  logic out_free;

  // Request decode.
  logic accept, frame_full, pix_take, drn_take, drn_is_last;

  // Line store ports.
  logic            ram_re, ram_we;
  logic [ColW-1:0] ram_raddr;
  logic            up_rd, mid_rd;

  // Thinning decision.
  logic nn, ss, ne, ee, se, ww, ctr, hit, value;

  // Clamp the dimensions to the usable range.
  always_comb begin
    w_eff = width_q;
    if (width_q < DimMin) begin
      w_eff = DimMin;
    end else if (width_q > DimW'(MaxColumns)) begin
      w_eff = DimW'(MaxColumns);
    end
    h_eff = height_q;
    if (height_q < DimMin) begin
      h_eff = DimMin;
    end else if (height_q > DimW'(MaxRows)) begin
      h_eff = DimW'(MaxRows);
    end
  end

  assign w_last = ColW'(w_eff - DimW'(1));
  assign h_row  = RowW'(h_eff);
  assign drn_m1 = drn_q - DimW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthReset;
      height_q <= HeightReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgImageWidth:  width_q  <= cfg_wdata_i;
        CfgImageHeight: height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Handshake: stall only when a pending result cannot move to the output.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_go      = s1_valid_q && (!s1_q.emit || out_free);
  assign in_stall_o = s1_valid_q && s1_q.emit && !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  // Pixels are taken until the frame is full; drains only after that.
  assign frame_full  = row_q >= h_row;
  assign pix_take    = accept && (mode_i == ModePixel) && !frame_full;
  assign drn_take    = accept && (mode_i == ModeDrain) && frame_full;
  assign drn_is_last = drn_q == w_eff;

  // Advance the raster position; a register write or the last drain restarts.
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    drn_d = drn_q;
    if (cfg_we_i) begin
      col_d = '0;
      row_d = '0;
      drn_d = '0;
    end else if (pix_take) begin
      if (col_q == w_last) begin
        col_d = '0;
        row_d = row_q + RowW'(1);
      end else begin
        col_d = col_q + ColW'(1);
      end
    end else if (drn_take) begin
      if (drn_is_last) begin
        col_d = '0;
        row_d = '0;
        drn_d = '0;
      end else begin
        drn_d = drn_q + DimW'(1);
      end
    end
  end

  // Read both line stores at the pixel column, or the bottom row for a drain.
  assign ram_re    = pix_take || (drn_take && (drn_q != '0));
  assign ram_raddr = pix_take ? col_q : drn_m1[ColW-1:0];

  always_comb begin
    s1_d.pix      = pix_take;
    s1_d.emit     = pix_take ? ((row_q >= RowW'(2)) ||
                                ((row_q == RowW'(1)) && (col_q != '0))) : 1'b1;
    s1_d.col0     = col_q == '0;
    s1_d.lastcol  = col_q == w_last;
    s1_d.interior = (row_q >= RowW'(2)) && (col_q >= ColW'(2));
    s1_d.pin      = pixel_in_i;
    s1_d.last     = drn_is_last;
    s1_d.dj0      = drn_q == '0;
    s1_d.wa       = col_q;
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (pix_take || drn_take) begin
      s1_valid_d = 1'b1;
    end else if (s1_go) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_take || drn_take) begin
      s1_q <= s1_d;
    end
  end

  // Upper store takes the old middle row; middle store takes the new pixel.
  assign ram_we = s1_go && s1_q.pix;

  btsp_ram #(
    .Width (1),
    .Depth (MaxColumns)
  ) u_upper (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_q.wa),
    .wdata_i (mid_rd),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (up_rd)
  );

  btsp_ram #(
    .Width (1),
    .Depth (MaxColumns)
  ) u_middle (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_q.wa),
    .wdata_i (s1_q.pin),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (mid_rd)
  );

  // Shift in the new column: {row r-2, row r-1, row r}.
  assign win_nxt = {win_q[5:0], up_rd, mid_rd, s1_q.pin};

  assign nn  = win_nxt[5];
  assign ss  = win_nxt[3];
  assign ne  = win_nxt[2];
  assign ee  = win_nxt[1];
  assign se  = win_nxt[0];
  assign ww  = win_nxt[7];
  assign ctr = win_nxt[4];
  assign hit = !ee && ww && ((nn && !se && !ss) || (!nn && !ne && ss));

  always_comb begin
    if (!s1_q.pix) begin
      value = s1_q.dj0 ? wrap_q : mid_rd;
    end else if (s1_q.col0) begin
      value = wrap_q;
    end else if (s1_q.interior) begin
      value = ctr && !hit;
    end else begin
      value = ctr;
    end
  end

  always_comb begin
    win_d  = win_q;
    wrap_d = wrap_q;
    if (cfg_we_i || (s1_go && !s1_q.pix && s1_q.last)) begin
      win_d = '0;
    end else if (s1_go && s1_q.pix) begin
      win_d = win_nxt;
    end
    // Keep the last column of the row above for the wrap-around result.
    if (s1_go && s1_q.pix && s1_q.lastcol) begin
      wrap_d = mid_rd;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    pix_out_d   = pix_out_q;
    last_out_d  = last_out_q;
    if (s1_go && s1_q.emit) begin
      out_valid_d = 1'b1;
      pix_out_d   = value;
      last_out_d  = !s1_q.pix && s1_q.last;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      drn_q       <= '0;
      s1_valid_q  <= 1'b0;
      win_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      col_q       <= col_d;
      row_q       <= row_d;
      drn_q       <= drn_d;
      s1_valid_q  <= s1_valid_d;
      win_q       <= win_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wrap_q     <= wrap_d;
    pix_out_q  <= pix_out_d;
    last_out_q <= last_out_d;
  end

  assign out_valid_o  = out_valid_q;
  assign pixel_out_o  = pix_out_q;
  assign frame_last_o = last_out_q;

  `BTSP_ASSERT_IMPL(a_no_rw_collide, clk_i, rst_ni, ram_re && ram_we, ram_raddr != s1_q.wa, "line store read and write hit the same column")
  `BTSP_ASSERT_IMPL(a_stall_cause, clk_i, rst_ni, in_stall_o, s1_valid_q && out_valid_q && out_stall_i, "input stalled without a blocked result")
  `BTSP_ASSERT_IMPL(a_drain_when_full, clk_i, rst_ni, drn_q != '0, row_q == h_row, "drain index advanced before the frame was full")
  `BTSP_ASSERT_IMPL(a_col_in_range, clk_i, rst_ni, 1'b1, DimW'(col_q) < w_eff, "input column beyond the image width")
  `BTSP_ASSERT_NEXT(a_last_flagged, clk_i, rst_ni, s1_go && !s1_q.pix && s1_q.last, out_valid_q && last_out_q, "final drain result not flagged")

endmodule

FILE: tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import btsp_pkg::*;

  // Generous ceiling: several times the slowest legal run (every request
  // waiting out the longest sender gap and every result the longest stall).
  localparam int unsigned CycleLimit     = 400_000;
  // A request that makes no result can still sit in the two-stage pipe after
  // the last result left, so hold off this many cycles before any register write.
  localparam int unsigned SettleCycles   = 4;
  localparam int unsigned RandomRequests = 170;
  localparam int unsigned MaxReports     = 20;

  typedef struct packed {
    logic pix;
    logic last;
  } thin_pixel_t;

  // ---------------------------------------------------------------------------
  // Block ports; every input starts from a known value
  // ---------------------------------------------------------------------------
  logic                clk_i;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i   = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  logic                mode_i      = ModePixel;
  logic                pixel_in_i  = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic                pixel_out_o;
  logic                frame_last_o;

  binary_thinning_subpass_3x3_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .pixel_in_i  (pixel_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .pixel_out_o (pixel_out_o),
    .frame_last_o(frame_last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Mirror of the block state: geometry registers, line stores, 3x3 window
  // ---------------------------------------------------------------------------
  logic [CfgDataW-1:0] width_reg  = WidthReset;
  logic [CfgDataW-1:0] height_reg = HeightReset;
  bit                  upper_line  [MaxColumns];
  bit                  middle_line [MaxColumns];
  logic [8:0]          win_bits = '0;  // three window columns, oldest in [8:6]
  int unsigned         in_col  = 0;
  int unsigned         in_row  = 0;
  int unsigned         out_cnt = 0;

  // Thinned pixels owed by the block, oldest first.
  thin_pixel_t         pixels_in_flight [$];

  int unsigned error_count     = 0;
  int unsigned cycle_count     = 0;
  int unsigned results_checked = 0;
  int unsigned requests_sent   = 0;
  int unsigned useful_requests = 0;  // requests the block did not just drop
  int unsigned frames_done     = 0;
  int unsigned pixels_thinned  = 0;
  int unsigned calm_left       = 0;  // requests left in a stretch with no gaps
  int unsigned stall_left      = 0;
  int unsigned stall_pick      = 0;
  thin_pixel_t head_pixel;

  task automatic report_mismatch(string msg);
    error_count++;
    if (error_count <= MaxReports) $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  // Register values outside 3..max are used as the nearest legal size.
  function automatic int unsigned eff_dim(logic [CfgDataW-1:0] v, int unsigned hi);
    if (v < 3) return 3;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void restart_frame();
    win_bits = '0;
    in_col   = 0;
    in_row   = 0;
    out_cnt  = 0;
  endfunction

  // Advance the mirrored state by one accepted request and queue the pixel
  // it releases, if any.
  function automatic void thin_window_step(logic req_mode, logic req_pixel);
    int unsigned w, h, r, c, first, j;
    logic a, b, wrap_pix, ctr, val, last, emit, hit;
    w    = eff_dim(width_reg, MaxColumns);
    h    = eff_dim(height_reg, MaxRows);
    last = 1'b0;
    if (req_mode == ModeDrain) begin
      // Drop a drain until the whole frame is in.
      if (in_row < h) return;
      first = w * h - w - 1;
      if (out_cnt < first || out_cnt - first > w) begin
        restart_frame();
        return;
      end
      useful_requests++;
      j   = out_cnt - first;
      val = (j == 0) ? upper_line[w-1] : middle_line[j-1];
      out_cnt++;
      if (j == w) begin
        // Final drain closes the frame; next pixel opens a fresh one.
        last = 1'b1;
        frames_done++;
        restart_frame();
      end
    end else begin
      // Drop pixels that arrive after the frame is full.
      if (in_row >= h) return;
      useful_requests++;
      r = in_row;
      c = (in_col >= w) ? w - 1 : in_col;
      a        = upper_line[c];
      b        = middle_line[c];
      wrap_pix = upper_line[w-1];
      upper_line[c]  = b;
      middle_line[c] = req_pixel;
      win_bits = {win_bits[5:0], a, b, req_pixel};

      emit = (r >= 2) || (r == 1 && c >= 1);
      val  = 1'b0;
      if (emit) begin
        if (c >= 1) begin
          ctr = win_bits[4];
          if (r >= 2 && r + 1 <= h && c >= 2 && c + 1 <= w) begin
            // West set, east clear, and either north set with south and
            // southeast clear, or north and northeast clear with south set.
            hit = !win_bits[1] && win_bits[7] &&
                  ((win_bits[5] && !win_bits[3] && !win_bits[0]) ||
                   (!win_bits[5] && !win_bits[2] && win_bits[3]));
            val = ctr && !hit;
            if (ctr && hit) pixels_thinned++;
          end else begin
            val = ctr;
          end
        end else begin
          // Column zero releases the last pixel of the row two above.
          val = wrap_pix;
        end
        out_cnt++;
      end
      if (c + 1 >= w) begin
        in_col = 0;
        in_row = r + 1;
      end else begin
        in_col = c + 1;
      end
      if (!emit) return;
    end
    pixels_in_flight.push_back('{pix: val, last: last});
  endfunction

  // ---------------------------------------------------------------------------
  // Output side: random stall pattern, mostly short, some long, some calm runs
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_pick = $urandom_range(0, 99);
      if (stall_pick < 10) begin
        out_stall_i <= 1'b0;
        stall_left = $urandom_range(40, 150);
      end else if (stall_pick < 55) begin
        out_stall_i <= 1'b0;
        stall_left = $urandom_range(1, 8);
      end else if (stall_pick < 90) begin
        out_stall_i <= 1'b1;
        stall_left = $urandom_range(1, 3);
      end else begin
        out_stall_i <= 1'b1;
        stall_left = $urandom_range(8, 30);
      end
    end else begin
      stall_left--;
    end
  end

  // Compare every result that leaves against the oldest pixel owed.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_checked++;
      if (pixels_in_flight.size() == 0) begin
        report_mismatch($sformatf("result pixel=%0b last=%0b with nothing pending",
                                  pixel_out_o, frame_last_o));
      end else begin
        head_pixel = pixels_in_flight.pop_front();
        if (pixel_out_o !== head_pixel.pix)
          report_mismatch($sformatf("pixel_out=%0b, want %0b (result %0d)",
                                    pixel_out_o, head_pixel.pix, results_checked));
        if (frame_last_o !== head_pixel.last)
          report_mismatch($sformatf("frame_last=%0b, want %0b (result %0d)",
                                    frame_last_o, head_pixel.last, results_checked));
      end
    end
  end

  // Watchdog: end the run if the block hangs.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Timeout after %0d cycles, %0d results still pending",
               cycle_count, pixels_in_flight.size());
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Present one request, hold it until accepted, then maybe idle a while.
  // Call only right after a rising edge.
  task automatic send_request(logic req_mode, logic req_pixel);
    int unsigned gap, roll;
    in_valid_i <= 1'b1;
    mode_i     <= req_mode;
    pixel_in_i <= req_pixel;
    do @(posedge clk_i); while (in_stall_o);
    thin_window_step(req_mode, req_pixel);
    requests_sent++;
    gap = 0;
    if (calm_left > 0) begin
      calm_left--;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 3) calm_left = $urandom_range(30, 120);
      else if (roll >= 92) gap = $urandom_range(6, 24);
      else if (roll >= 60) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Drop valid, let every owed pixel leave, then let the pipe settle.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pixels_in_flight.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Write one geometry register while the block is idle; it restarts the frame.
  task automatic write_register(cfg_idx_e idx, logic [CfgDataW-1:0] value);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgImageWidth) width_reg = value;
    else height_reg = value;
    restart_frame();
  endtask

  // Stream one whole frame at the current geometry and drain it. Noisy frames
  // sprinkle in early drains; extra pixels land after the frame is full.
  task automatic send_frame(int unsigned density, int unsigned extra_pixels, bit noisy);
    int unsigned w, h;
    w = eff_dim(width_reg, MaxColumns);
    h = eff_dim(height_reg, MaxRows);
    for (int unsigned i = 0; i < w * h; i++) begin
      if (noisy && $urandom_range(0, 99) < 3)
        send_request(ModeDrain, 1'($urandom_range(0, 1)));
      send_request(ModePixel, $urandom_range(0, 99) < density);
    end
    repeat (extra_pixels) send_request(ModePixel, 1'($urandom_range(0, 1)));
    for (int unsigned i = 0; i <= w; i++)
      send_request(ModeDrain, 1'($urandom_range(0, 1)));
  endtask

  // Out of reset: 640 columns. Results start on the second row, second pixel.
  task automatic test_reset_geometry();
    send_request(ModeDrain, 1'b1);
    repeat (648) send_request(ModePixel, 1'($urandom_range(0, 1)));
  endtask

  // Smallest frame, all clear then all set, back to back across a frame end.
  task automatic test_solid_frames();
    write_register(CfgImageWidth, CfgDataW'(3));
    write_register(CfgImageHeight, CfgDataW'(3));
    send_frame(0, 0, 1'b0);
    send_frame(100, 0, 1'b0);
    send_request(ModeDrain, 1'b0);
  endtask

  // Drains before the frame is full and pixels after it are both dropped.
  task automatic test_frame_overrun();
    write_register(CfgImageWidth, CfgDataW'(4));
    write_register(CfgImageHeight, CfgDataW'(3));
    send_request(ModeDrain, 1'b1);
    send_frame(50, 2, 1'b0);
  endtask

  // A register write in the middle of a frame throws the partial frame away.
  task automatic test_restart_on_write();
    write_register(CfgImageWidth, CfgDataW'(5));
    write_register(CfgImageHeight, CfgDataW'(4));
    repeat (13) send_request(ModePixel, 1'($urandom_range(0, 1)));
    write_register(CfgImageWidth, CfgDataW'(5));
    send_frame(60, 0, 1'b0);
  endtask

  // Register values below three, zero included, act as three.
  task automatic test_clamped_sizes();
    write_register(CfgImageWidth, '0);
    write_register(CfgImageHeight, CfgDataW'(2));
    send_frame(50, 0, 1'b0);
    write_register(CfgImageWidth, CfgDataW'(1));
    write_register(CfgImageHeight, '0);
    send_frame(50, 1, 1'b0);
  endtask

  // Mostly complete frames of random small sizes and densities, with the odd
  // aborted frame and noise requests mixed in.
  task automatic test_random_frames();
    int unsigned stop_at, w, h, k;
    stop_at = useful_requests + RandomRequests;
    while (useful_requests < stop_at) begin
      if ($urandom_range(0, 99) < 40) begin
        w = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 20) : $urandom_range(3, 12);
        h = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 12) : $urandom_range(3, 8);
        if (w == 3 && $urandom_range(0, 1)) w = $urandom_range(0, 2);
        if (h == 3 && $urandom_range(0, 1)) h = $urandom_range(0, 2);
        write_register(CfgImageWidth, CfgDataW'(w));
        write_register(CfgImageHeight, CfgDataW'(h));
      end
      if ($urandom_range(0, 9) == 0) begin
        w = eff_dim(width_reg, MaxColumns);
        h = eff_dim(height_reg, MaxRows);
        k = $urandom_range(1, w * h - 1);
        repeat (k) send_request(ModePixel, 1'($urandom_range(0, 1)));
        write_register(CfgImageHeight, height_reg);
      end else begin
        send_frame(25 + 25 * $urandom_range(0, 2),
                   ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0, 1'b1);
      end
    end
  endtask

  initial begin
    // Hold reset low from the start, release on an edge, never assert again.
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_geometry();
    test_solid_frames();
    test_frame_overrun();
    test_restart_on_write();
    test_clamped_sizes();
    test_random_frames();
    wait_idle();

    $display("Sent %0d requests and checked %0d results over %0d complete frames;",
             requests_sent, results_checked, frames_done);
    $display("%0d set pixels thinned away; frames from 3x3 to 20x12 and the reset width.",
             pixels_thinned);
    if (error_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/btsp_pkg.sv
rtl/btsp_ram.sv
rtl/binary_thinning_subpass_3x3_unit.sv
tb/tb_top.sv
